FILE: rtl/sacache_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sacache_pkg;

  // Cache geometry.
  localparam int SET_COUNT  = 4;
  localparam int WAY_COUNT  = 2;
  localparam int LINE_BYTES = 16;
  localparam int ADDR_BITS  = 32;

  // Address decomposition: offset, then set, then tag.
  localparam int OFFSET_BITS = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 0;
  localparam int SET_BITS    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - SET_BITS;
  localparam int WAY_BITS    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int RANK_BITS   = WAY_BITS;

  // Widths of the result fields.
  localparam int OUTCOME_BITS = 2;
  localparam int SET_OUT_BITS = 2;
  localparam int TAG_OUT_BITS = 26;
  localparam int WAY_OUT_BITS = 1;

  // Result codes.
  localparam logic [OUTCOME_BITS-1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [OUTCOME_BITS-1:0] OUTCOME_MISS  = 2'd1;
  localparam logic [OUTCOME_BITS-1:0] OUTCOME_EVICT = 2'd2;

  // One way of a set as held in the tag memory.
  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [RANK_BITS-1:0] rank;
  } way_entry_t;

  // One memory row holds every way of one set.
  typedef way_entry_t [WAY_COUNT-1:0] set_row_t;

  localparam int ROW_BITS = WAY_COUNT * (TAG_BITS + RANK_BITS);

endpackage

`default_nettype wire

FILE: rtl/set_assoc_cache_lru_lookup_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                                      Direction
// request   in_valid, in_stall, address                                  in (in_stall out)
// result    out_valid, out_stall, outcome, set_index, tag_value, way_used out (out_stall in)
//
// Each request is handled in steps: IDLE reads the set row from the tag memory,
// then LOOKUP compares, chooses the way and writes the updated row back.
// A new request is taken only once the last one has written its row back.
// Reset is synchronous; it clears all line valid bits, so no clearing pass.
// A finished result waits in the output register while the next request is
// read; the write-back stalls only if the output register is still full.

module set_assoc_cache_lru_lookup_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [sacache_pkg::ADDR_BITS-1:0]   address,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [sacache_pkg::OUTCOME_BITS-1:0]     outcome,
  output logic [sacache_pkg::SET_OUT_BITS-1:0]     set_index,
  output logic [sacache_pkg::TAG_OUT_BITS-1:0]     tag_value,
  output logic [sacache_pkg::WAY_OUT_BITS-1:0]     way_used
);

  typedef enum logic {
    IDLE,
    LOOKUP
  } state_t;

  state_t state;

  logic [sacache_pkg::SET_BITS-1:0]  req_set;
  logic [sacache_pkg::TAG_BITS-1:0]  req_tag;
  logic [sacache_pkg::WAY_COUNT-1:0] line_valid [sacache_pkg::SET_COUNT];

  logic                               rd_en;
  logic [sacache_pkg::SET_BITS-1:0]   rd_set;
  logic [sacache_pkg::TAG_BITS-1:0]   in_tag;
  logic [sacache_pkg::ROW_BITS-1:0]   rd_data;
  logic [sacache_pkg::ROW_BITS-1:0]   wr_data;
  logic                               wr_en;
  logic                               load;

  sacache_pkg::set_row_t              cur_row;
  sacache_pkg::set_row_t              new_row;
  logic [sacache_pkg::WAY_COUNT-1:0]  cur_valid;
  logic                               found;
  logic                               empty;
  logic [sacache_pkg::WAY_BITS-1:0]   sel_way;
  logic [sacache_pkg::RANK_BITS-1:0]  oldest;
  logic [sacache_pkg::RANK_BITS:0]    old_rank;
  logic [sacache_pkg::OUTCOME_BITS-1:0] sel_outcome;

  // Address decode for the incoming request.
  assign rd_set = address[sacache_pkg::OFFSET_BITS +: sacache_pkg::SET_BITS];
  assign in_tag = address[sacache_pkg::ADDR_BITS-1 :
                          sacache_pkg::OFFSET_BITS + sacache_pkg::SET_BITS];

  // A request is taken only between lookups.
  assign in_stall = (state != IDLE);
  assign rd_en    = (state == IDLE) && in_valid;

  // The write-back and the result load happen together once the output is free.
  assign load  = !out_valid || !out_stall;
  assign wr_en = (state == LOOKUP) && load;

  sacache_ram #(
    .WIDTH (sacache_pkg::ROW_BITS),
    .DEPTH (sacache_pkg::SET_COUNT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (req_set),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_set),
    .rdata (rd_data)
  );

  // Compare every way, pick the hit, the first empty way or the oldest way,
  // and age the lines that were newer than the chosen one.
  always_comb begin
    cur_row   = sacache_pkg::set_row_t'(rd_data);
    cur_valid = line_valid[req_set];
    found     = 1'b0;
    empty     = 1'b0;
    sel_way   = '0;
    oldest    = '0;

    for (int w = 0; w < sacache_pkg::WAY_COUNT; w++) begin
      if (!found && cur_valid[w] && (cur_row[w].tag == req_tag)) begin
        found   = 1'b1;
        sel_way = sacache_pkg::WAY_BITS'(w);
      end
    end

    if (!found) begin
      for (int w = 0; w < sacache_pkg::WAY_COUNT; w++) begin
        if (!empty) begin
          if (!cur_valid[w]) begin
            empty   = 1'b1;
            sel_way = sacache_pkg::WAY_BITS'(w);
          end else if ((w == 0) || (cur_row[w].rank > oldest)) begin
            oldest  = cur_row[w].rank;
            sel_way = sacache_pkg::WAY_BITS'(w);
          end
        end
      end
    end

    if (found) begin
      sel_outcome = sacache_pkg::OUTCOME_HIT;
    end else if (empty) begin
      sel_outcome = sacache_pkg::OUTCOME_MISS;
    end else begin
      sel_outcome = sacache_pkg::OUTCOME_EVICT;
    end

    // Rank of the chosen line before the access; an empty line counts as oldest.
    if (cur_valid[sel_way]) begin
      old_rank = {1'b0, cur_row[sel_way].rank};
    end else begin
      old_rank = (sacache_pkg::RANK_BITS + 1)'(sacache_pkg::WAY_COUNT);
    end

    new_row = cur_row;
    for (int v = 0; v < sacache_pkg::WAY_COUNT; v++) begin
      if ((sacache_pkg::WAY_BITS'(v) != sel_way) && cur_valid[v] &&
          ({1'b0, cur_row[v].rank} < old_rank)) begin
        new_row[v].rank = cur_row[v].rank + 1'b1;
      end
    end
    new_row[sel_way].rank = '0;
    new_row[sel_way].tag  = req_tag;

    wr_data = sacache_pkg::ROW_BITS'(new_row);
  end

  // Sequencer, valid bits and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      for (int s = 0; s < sacache_pkg::SET_COUNT; s++) begin
        line_valid[s] <= '0;
      end
    end else begin
      // The result register fills on a write-back and empties when taken.
      if (wr_en) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            req_set <= rd_set;
            req_tag <= in_tag;
            state   <= LOOKUP;
          end
        end
        LOOKUP: begin
          if (load) begin
            line_valid[req_set][sel_way] <= 1'b1;
            outcome   <= sel_outcome;
            set_index <= sacache_pkg::SET_OUT_BITS'(req_set);
            tag_value <= req_tag[sacache_pkg::TAG_OUT_BITS-1:0];
            way_used  <= sel_way[sacache_pkg::WAY_OUT_BITS-1:0];
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // An accepted request moves the sequencer into its lookup state.
  a_accept_then_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == LOOKUP))
    else $error("request accepted without entering lookup");

  // A new result appears only out of a lookup that wrote its set back.
  a_result_from_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(wr_en))
    else $error("result loaded outside a lookup");

  // Eviction is chosen only when every way of the set is valid.
  a_evict_full_set: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (sel_outcome == sacache_pkg::OUTCOME_EVICT)) |-> (&line_valid[req_set]))
    else $error("eviction from a set with an empty way");

  // A hit always lands on a valid line.
  a_hit_way_valid: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (sel_outcome == sacache_pkg::OUTCOME_HIT)) |-> line_valid[req_set][sel_way])
    else $error("hit on an invalid line");
`endif

endmodule

`default_nettype wire

FILE: rtl/sacache_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sacache_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port; read data holds when re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
